// ===== design/kns_pkg.sv =====
// kns_pkg: shared types, code point constants and the kana folding function
// used by the substring matcher top level and its compare cells
`timescale 1ns / 1ps

package kns_pkg;

   localparam int MaxBlocksDefault = 64;
   localparam int CpWidth          = 21;
   localparam int GroupSize        = 32;

   typedef logic [CpWidth-1:0] cp_type;

   // request kinds carried on tuser
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_WORD   = 2'd2;
   localparam logic [1:0] CMD_END    = 2'd3;

   localparam cp_type CP_LONG_VOWEL = 21'h030FC;
   localparam cp_type CP_FW_HYPHEN  = 21'h0FF0D;
   localparam cp_type CP_HBAR       = 21'h02015;
   localparam cp_type CP_SMALL_TSU  = 21'h03063;
   localparam cp_type CP_TSU        = 21'h03064;
   localparam cp_type CP_SMALL_WA   = 21'h0308E;
   localparam cp_type CP_WA         = 21'h0308F;
   localparam cp_type CP_VU         = 21'h03094;
   localparam cp_type CP_U          = 21'h03046;
   localparam cp_type CP_SMALL_KA   = 21'h03095;
   localparam cp_type CP_KA         = 21'h0304B;
   localparam cp_type CP_SMALL_KE   = 21'h03096;
   localparam cp_type CP_KE         = 21'h03051;

   typedef struct packed {
      logic   keep;
      cp_type ch;
   } norm_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic   clr_hay;
      logic   clr_word;
      logic   step;
      logic   first;
      cp_type ch;
   } cell_ctl_type;

   function automatic norm_type kana_normalize(input cp_type c);
      norm_type r;
      r.keep = 1'b1;
      r.ch   = c;
      if (c == CP_LONG_VOWEL || c == CP_FW_HYPHEN || c == CP_HBAR) begin
         r.keep = 1'b0;
      end else if (c inside {[21'h03041:21'h03049]} && c[0]) begin
         r.ch = c + 21'd1;                    // small a i u e o
      end else if (c inside {[21'h0304C:21'h03062]} && !c[0]) begin
         r.ch = c - 21'd1;                    // voiced ka through chi rows
      end else if (c == CP_SMALL_TSU) begin
         r.ch = CP_TSU;
      end else if (c == 21'h03065 || c == 21'h03067 || c == 21'h03069) begin
         r.ch = c - 21'd1;                    // voiced tsu te to
      end else if (c inside {[21'h03070:21'h0307D]}) begin
         // ha row: fold voiced and semi-voiced onto the plain form
         case (c[3:0])
            4'h0, 4'h3, 4'h6, 4'h9, 4'hC: r.ch = c - 21'd1;
            4'h1, 4'h4, 4'h7, 4'hA, 4'hD: r.ch = c - 21'd2;
            default:                      r.ch = c;
         endcase
      end else if (c == 21'h03083 || c == 21'h03085 || c == 21'h03087) begin
         r.ch = c + 21'd1;                    // small ya yu yo
      end else if (c == CP_SMALL_WA) begin
         r.ch = CP_WA;
      end else if (c == CP_VU) begin
         r.ch = CP_U;
      end else if (c == CP_SMALL_KA) begin
         r.ch = CP_KA;
      end else if (c == CP_SMALL_KE) begin
         r.ch = CP_KE;
      end
      return r;
   endfunction

endpackage

// ===== design/kana_normalized_substring_match.sv =====
// kana_normalized_substring_match: normalized kana substring search built
// from a row of compare cells and a registered or-tree; depends on kns_pkg,
// kns_cell and kns_any_tree
// clear, append and word requests go back to back unless an end is pending
// end of word: the or-tree register loads, then rsp once it is free
// the result is registered onto rsp in the cycle after the evaluation cycle
// reset (synchronous, active high) empties the haystack and the word state
`timescale 1ns / 1ps

module kana_normalized_substring_match
   import kns_pkg::*;
#(
   parameter int MAX_BLOCKS = MaxBlocksDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] code_point, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] hit, rest zero
);

   localparam int LenWidth = $clog2(MAX_BLOCKS + 1);

   // haystack fill count and word tracking
   logic [LenWidth-1:0] hay_len_ff, hay_len_in;
   logic                word_active_ff, word_active_in;
   // end-of-word evaluation pending
   logic                eval_ff, eval_in;
   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;

   logic                  req_fire;
   logic [1:0]            cmd;
   norm_type              norm;
   logic                  append_ok;
   logic                  eval_done;
   logic                  any_match;
   cell_ctl_type          ctl;
   logic [MAX_BLOCKS-1:0] match;

   assign req_tready = !eval_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = req_tuser;
   assign norm       = kana_normalize(req_tdata[CpWidth-1:0]);

   // append only a kept character into a haystack that has room
   assign append_ok = req_fire && (cmd == CMD_APPEND) && norm.keep &&
                      (hay_len_ff != LenWidth'(MAX_BLOCKS));

   // evaluation finishes once the result register is free
   assign eval_done = eval_ff && (!rsp_valid_ff || rsp_tready);

   // broadcast to the cells
   always_comb begin
      ctl.ch       = norm.ch;
      ctl.first    = !word_active_ff;
      ctl.clr_hay  = req_fire && (cmd == CMD_CLEAR);
      ctl.clr_word = eval_done ||
                     (req_fire && (cmd == CMD_CLEAR || cmd == CMD_APPEND));
      ctl.step     = req_fire && (cmd == CMD_WORD) && norm.keep;
   end

   // row of cells, match bit rippling one position per word character
   for (genvar p = 0; p < MAX_BLOCKS; p++) begin : g_cell
      logic prev;
      if (p == 0) begin : g_head
         assign prev = 1'b0;
      end else begin : g_link
         assign prev = match[p-1];
      end
      kns_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_en      (append_ok && (hay_len_ff == LenWidth'(p))),
         .prev_match (prev),
         .match      (match[p])
      );
   end

   kns_any_tree #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_any_tree (
      .clock     (clock),
      .match     (match),
      .any_match (any_match)
   );

   always_comb begin
      hay_len_in     = hay_len_ff;
      word_active_in = word_active_ff;
      eval_in        = eval_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_hit_in     = rsp_hit_ff;

      if (ctl.clr_hay) begin
         hay_len_in = '0;
      end else if (append_ok) begin
         hay_len_in = hay_len_ff + LenWidth'(1);
      end

      if (ctl.clr_word) begin
         word_active_in = 1'b0;
      end else if (ctl.step) begin
         word_active_in = 1'b1;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire && (cmd == CMD_END)) begin
         eval_in = 1'b1;
      end else if (eval_done) begin
         // empty word never hits
         eval_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_hit_in   = word_active_ff && any_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hay_len_ff     <= '0;
         word_active_ff <= 1'b0;
         eval_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hay_len_ff     <= hay_len_in;
         word_active_ff <= word_active_in;
         eval_ff        <= eval_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_hit_ff};

endmodule

// ===== design/kns_cell.sv =====
// kns_cell: one haystack position, holding its character, a valid flag and
// the match bit handed on to the next cell; depends on kns_pkg
`timescale 1ns / 1ps

module kns_cell
   import kns_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         wr_en,
   input  logic         prev_match,
   output logic         match
);

   cp_type hay_ff, hay_in;
   logic   valid_ff, valid_in;
   logic   match_ff, match_in;
   logic   eq;

   assign eq = valid_ff && (hay_ff == ctl.ch);

   always_comb begin
      hay_in   = hay_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (wr_en) begin
         hay_in   = ctl.ch;
         valid_in = 1'b1;
      end
      if (ctl.clr_hay) begin
         valid_in = 1'b0;
      end
      if (ctl.clr_word) begin
         match_in = 1'b0;
      end else if (ctl.step) begin
         match_in = (ctl.first || prev_match) && eq;
      end
   end

   always_ff @(posedge clock) begin
      hay_ff <= hay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   assign match = match_ff;

endmodule

// ===== design/kns_any_tree.sv =====
// kns_any_tree: registered or-reduction of the cell match bits, groups of
// GroupSize folded into one flop each; depends on kns_pkg
`timescale 1ns / 1ps

module kns_any_tree
   import kns_pkg::*;
#(
   parameter int MAX_BLOCKS = MaxBlocksDefault
) (
   input  logic                  clock,
   input  logic [MAX_BLOCKS-1:0] match,
   output logic                  any_match
);

   localparam int NumGroups = (MAX_BLOCKS + GroupSize - 1) / GroupSize;

   logic [NumGroups-1:0] grp_ff, grp_in;

   always_comb begin
      grp_in = '0;
      for (int g = 0; g < NumGroups; g++) begin
         for (int b = 0; b < GroupSize; b++) begin
            if (g * GroupSize + b < MAX_BLOCKS) begin
               grp_in[g] = grp_in[g] | match[g * GroupSize + b];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign any_match = |grp_ff;

endmodule
